### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent holds in a cycle, consequent holds in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/bft_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Types, field widths and outcome codes shared by the flow table modules.
// ----------------------------------------------------------------------------
package bft_pkg;

    localparam int DEFAULT_MAX_STREAMS = 64;
    localparam int STREAM_INDEX_W      = 6;
    localparam int STREAMS_IN_USE_W    = 7;

    localparam logic [1:0] OUTCOME_MATCHED = 2'd0;
    localparam logic [1:0] OUTCOME_OPENED  = 2'd1;
    localparam logic [1:0] OUTCOME_IGNORED = 2'd2;
    localparam logic [1:0] OUTCOME_FULL    = 2'd3;

    typedef struct packed {
        logic        start_of_capture;
        logic        is_ip;
        logic        is_tcp;
        logic        is_udp;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } in_item_t;

    typedef struct packed {
        logic [STREAM_INDEX_W-1:0]   stream_index;
        logic [1:0]                  outcome;
        logic [STREAMS_IN_USE_W-1:0] streams_in_use;
    } out_item_t;

    typedef struct packed {
        logic        is_udp;
        logic [31:0] client_address;
        logic [31:0] server_address;
        logic [15:0] client_port;
        logic [15:0] server_port;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       step;
        logic       insert;
        logic       finish;
        logic       deliver;
        logic [1:0] outcome;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flow;
        logic empty;
        logic hit;
        logic last;
        logic full;
        logic out_free;
    } dp_status_t;

endpackage

### sv/bft_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/bft_ctrl.sv
// ----------------------------------------------------------------------------
// Flow table controller
// Sequences acceptance, the table scan, insertion and result hand-off.
// ----------------------------------------------------------------------------
module bft_ctrl
    import bft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load     = 1'b1;
                    state_next   = ST_SCAN;
                    s_ready_next = 1'b0;
                end
            end
            ST_SCAN: begin
                // The scan visits one entry per cycle and stops at the first hit.
                priority if (!sts.flow) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = OUTCOME_IGNORED;
                    state_next  = ST_DELIVER;
                end else if (sts.hit) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = OUTCOME_MATCHED;
                    state_next  = ST_DELIVER;
                end else if (sts.empty || sts.last) begin
                    cmd.finish = 1'b1;
                    state_next = ST_DELIVER;
                    if (sts.full) begin
                        cmd.outcome = OUTCOME_FULL;
                    end else begin
                        cmd.insert  = 1'b1;
                        cmd.outcome = OUTCOME_OPENED;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_DELIVER: begin
                if (sts.out_free) begin
                    cmd.deliver  = 1'b1;
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

### sv/bft_dp.sv
// ----------------------------------------------------------------------------
// Flow table datapath
// Holds the packet key, the entry RAM, the fill count and the result register.
// ----------------------------------------------------------------------------
module bft_dp
    import bft_pkg::*;
#(
    parameter int MAX_STREAMS = DEFAULT_MAX_STREAMS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_item,
    input  logic       m_ready,
    output logic       m_valid,
    output out_item_t  m_item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t sts
);

    localparam int IDX_W = $clog2(MAX_STREAMS);
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam int SUM_W = CNT_W + 1;

    in_item_t         key_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] res_index_reg;
    logic [1:0]       res_outcome_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg;

    entry_t           wr_entry, rd_entry;
    logic             key_udp;
    logic             fwd, rev;
    logic [SUM_W-1:0] idx_plus;

    logic [IDX_W+STREAM_INDEX_W-1:0]   index_ext;
    logic [CNT_W+STREAMS_IN_USE_W-1:0] count_ext;

    // Both flags set counts as TCP.
    assign key_udp = !key_reg.is_tcp;

    assign wr_entry.is_udp         = key_udp;
    assign wr_entry.client_address = key_reg.source_address;
    assign wr_entry.server_address = key_reg.destination_address;
    assign wr_entry.client_port    = key_reg.source_port;
    assign wr_entry.server_port    = key_reg.destination_port;

    // Entries fill in order, so an index below the count marks a live entry.
    bft_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_STREAMS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .raddr (idx_next),
        .rdata (rd_entry)
    );

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.step) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_item.start_of_capture) begin
            count_next = '0;
        end else if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign fwd = rd_entry.client_address == key_reg.source_address
              && rd_entry.client_port    == key_reg.source_port
              && rd_entry.server_address == key_reg.destination_address
              && rd_entry.server_port    == key_reg.destination_port;
    assign rev = rd_entry.client_address == key_reg.destination_address
              && rd_entry.client_port    == key_reg.destination_port
              && rd_entry.server_address == key_reg.source_address
              && rd_entry.server_port    == key_reg.source_port;

    assign idx_plus = SUM_W'(idx_reg) + SUM_W'(1);

    assign sts.flow     = key_reg.is_ip && (key_reg.is_tcp || key_reg.is_udp);
    assign sts.empty    = count_reg == '0;
    assign sts.hit      = !sts.empty && (rd_entry.is_udp == key_udp) && (fwd || rev);
    assign sts.last     = idx_plus == SUM_W'(count_reg);
    assign sts.full     = count_reg == CNT_W'(MAX_STREAMS);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.deliver) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Wide tables report index and count masked to the field widths.
    assign index_ext = {{STREAM_INDEX_W{1'b0}}, res_index_reg};
    assign count_ext = {{STREAMS_IN_USE_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            key_reg <= s_item;
        end
        if (cmd.finish) begin
            res_outcome_reg <= cmd.outcome;
            if (cmd.insert) begin
                res_index_reg <= count_reg[IDX_W-1:0];
            end else if (cmd.outcome == OUTCOME_MATCHED) begin
                res_index_reg <= idx_reg;
            end else begin
                res_index_reg <= '0;
            end
        end
        if (cmd.deliver) begin
            m_item_reg.stream_index   <= index_ext[STREAM_INDEX_W-1:0];
            m_item_reg.outcome        <= res_outcome_reg;
            m_item_reg.streams_in_use <= count_ext[STREAMS_IN_USE_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### sv/bidirectional_flow_table.sv
// ----------------------------------------------------------------------------
// Bidirectional flow table
// Packets are handled one at a time: the next is accepted only after the result
// of the last is delivered. The scan visits n entries at one a cycle through the
// table RAM read port: n = k + 1 for a match at index k, the stream count (at
// least 1) for a miss, and 1 for an ignored packet.
// Synchronous reset empties the table at once by clearing the fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bidirectional_flow_table
    import bft_pkg::*;
#(
    parameter int MAX_STREAMS = DEFAULT_MAX_STREAMS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    bft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bft_dp #(
        .MAX_STREAMS(MAX_STREAMS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .cmd     (cmd),
        .sts     (sts)
    );

    // One transaction is in work at a time.
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A full table is never written.
    `ASSERT_IMPLIES(a_no_insert_full, aclk, aresetn, cmd.insert, !sts.full)
    // A waiting result is never overwritten.
    `ASSERT_IMPLIES(a_deliver_free, aclk, aresetn, cmd.deliver, sts.out_free)

endmodule
